>>> rtl/core/aq_pkg.sv
// Shared types, constants and helper functions for the affine 8-bit quantizer.
// Depends on nothing; every module of the quantizer imports this package.
`default_nettype none

package aq_pkg;

  // Quotient bits produced per divider stage, and the number of divider stages.
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = 7;
  localparam int QBITS          = BITS_PER_STAGE * DIV_STAGES;

  // Register stages behind the input register, equal on both conversion paths.
  localparam int QUANT_LAT = DIV_STAGES + 3;
  localparam int DQ_STAGES = 3;
  localparam int DQ_DELAY  = QUANT_LAT - DQ_STAGES;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_SCALE = 2'd1;
  localparam logic [1:0] CFG_ZP    = 2'd2;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] QNAN_BITS   = 32'h7FC0_0000;

  typedef enum logic [1:0] {
    MODE_F2U = 2'd0,
    MODE_U2F = 2'd1,
    MODE_F2I = 2'd2,
    MODE_I2F = 2'd3
  } mode_t;

  // Outcome class of a quantize operation, settled before the division.
  typedef enum logic [1:0] {
    QC_LO   = 2'd0,
    QC_HI   = 2'd1,
    QC_ZERO = 2'd2,
    QC_DIV  = 2'd3
  } qclass_t;

  typedef struct packed {
    logic [31:0] real_value_bits;
    logic [7:0]  code_in;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] real_result_bits;
    logic [7:0]  code_out;
    logic        bad_scale;
    logic        last_out;
  } out_item_t;

  typedef struct packed {
    qclass_t            qclass;
    logic               sign;
    logic signed [10:0] exp;
  } qside_t;

  // State of one item inside the divider pipeline.
  typedef struct packed {
    qside_t           side;
    logic [25:0]      rem;
    logic [QBITS-1:0] quo;
  } qdiv_t;

  // Index of the highest set bit, zero for a zero word.
  function automatic logic [4:0] msb_idx32(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        idx = i[4:0];
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/aq_div_stage.sv
// One registered stage of the restoring significand divider, several bits a stage.
// Depends on aq_pkg for the stage state type and the bits per stage.
`default_nettype none

module aq_div_stage (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [23:0]   divisor,
  input  aq_pkg::qdiv_t      in_data,
  output aq_pkg::qdiv_t      out_data
);
  import aq_pkg::*;

  qdiv_t       data_r;
  qdiv_t       data_nxt;
  logic [25:0] r;
  logic [QBITS-1:0] q;

  // Compare, subtract and shift once for each quotient bit of this stage.
  always_comb begin
    r = in_data.rem;
    q = in_data.quo;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      if (r >= {2'b00, divisor}) begin
        r = r - {2'b00, divisor};
        q = {q[QBITS-2:0], 1'b1};
      end else begin
        q = {q[QBITS-2:0], 1'b0};
      end
      r = {r[24:0], 1'b0};
    end
    data_nxt      = in_data;
    data_nxt.rem  = r;
    data_nxt.quo  = q;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_data = data_r;

endmodule

`default_nettype wire

>>> rtl/core/aq_quant.sv
// Quantize path: operand unpacking, pipelined division, fp32 rounding of the
// quotient, integer rounding, zero point offset and clipping. Uses aq_pkg and aq_div_stage.
`default_nettype none

module aq_quant (
  input  wire logic          clk,
  input  wire logic          en,
  input  aq_pkg::mode_t      mode,
  input  wire logic [31:0]   scale_bits,
  input  wire logic [7:0]    zero_point,
  input  wire logic [31:0]   x_bits,
  output logic [7:0]         code
);
  import aq_pkg::*;

  // Operand fields and normalized significands.
  logic [7:0]         xe, se;
  logic [22:0]        xf, sf;
  logic [4:0]         xp, sp;
  logic [23:0]        xm, sm;
  logic signed [10:0] xexp, sexp;
  logic               xnan, xinf, xzero, snan, sinf, szero, sdiff;
  qdiv_t              prep_r, prep_nxt;
  qdiv_t              div_s [DIV_STAGES+1];

  always_comb begin
    xe = x_bits[30:23];
    xf = x_bits[22:0];
    se = scale_bits[30:23];
    sf = scale_bits[22:0];
    xp = msb_idx32({9'b0, xf});
    sp = msb_idx32({9'b0, sf});
    if (xe != 8'd0) begin
      xm   = {1'b1, xf};
      xexp = $signed({3'b000, xe}) - 11'sd127;
    end else begin
      xm   = {1'b0, xf} << (5'd23 - xp);
      xexp = $signed({6'b0, xp}) - 11'sd149;
    end
    if (se != 8'd0) begin
      sm   = {1'b1, sf};
      sexp = $signed({3'b000, se}) - 11'sd127;
    end else begin
      sm   = {1'b0, sf} << (5'd23 - sp);
      sexp = $signed({6'b0, sp}) - 11'sd149;
    end
  end

  // Special operands decide the outcome before the division starts.
  always_comb begin
    xnan  = (xe == 8'hFF) && (xf != 23'd0);
    xinf  = (xe == 8'hFF) && (xf == 23'd0);
    xzero = (x_bits[30:0] == 31'd0);
    snan  = (se == 8'hFF) && (sf != 23'd0);
    sinf  = (se == 8'hFF) && (sf == 23'd0);
    szero = (scale_bits[30:0] == 31'd0);
    sdiff = x_bits[31] ^ scale_bits[31];

    prep_nxt.side.sign = sdiff;
    prep_nxt.side.exp  = xexp - sexp;
    prep_nxt.rem       = {2'b00, xm};
    prep_nxt.quo       = '0;
    if (xnan) begin
      prep_nxt.side.qclass = QC_LO;
    end else if (szero) begin
      prep_nxt.side.qclass = (xzero || sdiff) ? QC_LO : QC_HI;
    end else if (snan) begin
      prep_nxt.side.qclass = QC_LO;
    end else if (xinf) begin
      prep_nxt.side.qclass = (sinf || sdiff) ? QC_LO : QC_HI;
    end else if (sinf || xzero) begin
      prep_nxt.side.qclass = QC_ZERO;
    end else begin
      prep_nxt.side.qclass = QC_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  assign div_s[0] = prep_r;

  // Divider: users keep the scale register stable while items are in flight; not enforced.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    aq_div_stage u_stage (
      .clk      (clk),
      .en       (en),
      .divisor  (sm),
      .in_data  (div_s[g]),
      .out_data (div_s[g+1])
    );
  end

  // Round the quotient significand to fp32, ties to even.
  qdiv_t              dq;
  logic [23:0]        qsig;
  logic               qg, qst;
  logic signed [10:0] qe;
  logic [24:0]        qrnd;
  logic [23:0]        r1_sig_r, r1_sig_nxt;
  logic signed [10:0] r1_exp_r, r1_exp_nxt;
  qside_t             r1_side_r;

  always_comb begin
    dq = div_s[DIV_STAGES];
    if (dq.quo[QBITS-1]) begin
      qsig = dq.quo[QBITS-1:QBITS-24];
      qg   = dq.quo[QBITS-25];
      qst  = (|dq.quo[QBITS-26:0]) | (|dq.rem);
      qe   = dq.side.exp;
    end else begin
      qsig = dq.quo[QBITS-2:QBITS-25];
      qg   = dq.quo[QBITS-26];
      qst  = (|dq.quo[QBITS-27:0]) | (|dq.rem);
      qe   = dq.side.exp - 11'sd1;
    end
    qrnd = {1'b0, qsig} + {24'd0, qg & (qst | qsig[0])};
    if (qrnd[24]) begin
      r1_sig_nxt = qrnd[24:1];
      r1_exp_nxt = qe + 11'sd1;
    end else begin
      r1_sig_nxt = qrnd[23:0];
      r1_exp_nxt = qe;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sig_r  <= r1_sig_nxt;
      r1_exp_r  <= r1_exp_nxt;
      r1_side_r <= dq.side;
    end
  end

  // Round to an integer, ties to even, then offset and clip to the code range.
  logic               is_int;
  logic [4:0]         sh;
  logic [23:0]        ipart, below;
  logic               half, rest;
  logic [9:0]         mag;
  logic signed [10:0] t;
  logic signed [11:0] v, lo, hi, zpx;
  logic [7:0]         code_r, code_nxt;

  always_comb begin
    is_int = (mode == MODE_F2I);
    lo     = is_int ? -12'sd127 : 12'sd0;
    hi     = is_int ? 12'sd127 : 12'sd255;
    zpx    = is_int ? $signed({{4{zero_point[7]}}, zero_point})
                    : $signed({4'b0000, zero_point});
    sh     = 5'd23 - r1_exp_r[4:0];
    ipart  = r1_sig_r >> sh;
    below  = r1_sig_r & ((24'd1 << (sh - 5'd1)) - 24'd1);
    half   = |(r1_sig_r & (24'd1 << (sh - 5'd1)));
    rest   = |below;
    mag    = ipart[9:0] + {9'd0, half & (rest | ipart[0])};
    t      = r1_side_r.sign ? (11'sd0 - $signed({1'b0, mag})) : $signed({1'b0, mag});
    case (r1_side_r.qclass)
      QC_LO:   v = lo;
      QC_HI:   v = hi;
      QC_ZERO: v = zpx;
      default: begin
        if (r1_exp_r >= 11'sd9) begin
          v = r1_side_r.sign ? lo : hi;
        end else if (r1_exp_r < -11'sd1) begin
          v = zpx;
        end else begin
          v = $signed({t[10], t}) + zpx;
        end
      end
    endcase
    if (v < lo) begin
      v = lo;
    end
    if (v > hi) begin
      v = hi;
    end
    code_nxt = v[7:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r <= code_nxt;
    end
  end

  assign code = code_r;

endmodule

`default_nettype wire

>>> rtl/core/aq_dequant.sv
// Dequantize path: code minus zero point times the fp32 scale, rounded to
// nearest even, then delayed to line up with the quantize path. Uses aq_pkg.
`default_nettype none

module aq_dequant (
  input  wire logic          clk,
  input  wire logic          en,
  input  aq_pkg::mode_t      mode,
  input  wire logic [31:0]   scale_bits,
  input  wire logic [7:0]    zero_point,
  input  wire logic [7:0]    code,
  output logic [31:0]        real_bits
);
  import aq_pkg::*;

  // Stage one: signed difference and the significand product.
  logic signed [9:0] diff;
  logic [7:0]        absd;
  logic [7:0]        se, es_eff;
  logic [23:0]       sig_s;
  logic [31:0]       p1_nxt, p1_r;
  logic [7:0]        es1_r;
  logic              sign1_nxt, sign1_r, snan1_r, sinf1_r, dzero1_r;

  always_comb begin
    if (mode == MODE_I2F) begin
      diff = $signed({{2{code[7]}}, code}) - $signed({{2{zero_point[7]}}, zero_point});
    end else begin
      diff = $signed({2'b00, code}) - $signed({2'b00, zero_point});
    end
    absd      = diff[9] ? 8'(-diff) : diff[7:0];
    se        = scale_bits[30:23];
    sig_s     = {se != 8'd0, scale_bits[22:0]};
    es_eff    = (se == 8'd0) ? 8'd1 : se;
    p1_nxt    = {24'd0, absd} * {8'd0, sig_s};
    sign1_nxt = scale_bits[31] ^ diff[9];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= p1_nxt;
      es1_r    <= es_eff;
      sign1_r  <= sign1_nxt;
      snan1_r  <= (se == 8'hFF) && (scale_bits[22:0] != 23'd0);
      sinf1_r  <= (se == 8'hFF) && (scale_bits[22:0] == 23'd0);
      dzero1_r <= (absd == 8'd0);
    end
  end

  // Stage two: leading one position and the biased result exponent.
  logic [31:0]       p2_r;
  logic [4:0]        l2_r;
  logic [7:0]        es2_r;
  logic signed [9:0] b2_r;
  logic              sign2_r, snan2_r, sinf2_r, dzero2_r, pzero2_r;
  logic [4:0]        l1;

  always_comb begin
    l1 = msb_idx32(p1_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_r     <= p1_r;
      l2_r     <= l1;
      es2_r    <= es1_r;
      b2_r     <= $signed({5'd0, l1}) + $signed({2'b00, es1_r}) - 10'sd23;
      sign2_r  <= sign1_r;
      snan2_r  <= snan1_r;
      sinf2_r  <= sinf1_r;
      dzero2_r <= dzero1_r;
      pzero2_r <= (p1_r == 32'd0);
    end
  end

  // Stage three: round, pack and handle the special results.
  logic [4:0]        rsh;
  logic [31:0]       rshift, lshift, sub;
  logic              g, st;
  logic [24:0]       rnd;
  logic [23:0]       m;
  logic signed [9:0] eb;
  logic [31:0]       res_nxt, res_r;

  always_comb begin
    rsh    = l2_r - 5'd23;
    rshift = p2_r >> rsh;
    lshift = p2_r << (5'd23 - l2_r);
    sub    = p2_r << (es2_r - 8'd1);
    g      = |(p2_r & (32'd1 << (rsh - 5'd1)));
    st     = |(p2_r & ((32'd1 << (rsh - 5'd1)) - 32'd1));
    rnd    = {1'b0, rshift[23:0]} + {24'd0, g & (st | rshift[0])};
    eb     = b2_r;
    if (l2_r > 5'd23) begin
      if (rnd[24]) begin
        m  = rnd[24:1];
        eb = b2_r + 10'sd1;
      end else begin
        m  = rnd[23:0];
      end
    end else begin
      m = lshift[23:0];
    end

    if (snan2_r) begin
      res_nxt = QNAN_BITS;
    end else if (sinf2_r) begin
      res_nxt = dzero2_r ? QNAN_BITS : {sign2_r, 8'hFF, 23'd0};
    end else if (pzero2_r) begin
      res_nxt = {sign2_r, 31'd0};
    end else if (b2_r >= 10'sd1) begin
      if (eb >= 10'sd255) begin
        res_nxt = {sign2_r, 8'hFF, 23'd0};
      end else begin
        res_nxt = {sign2_r, eb[7:0], m[22:0]};
      end
    end else begin
      res_nxt = {sign2_r, 8'd0, sub[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  // Delay line that matches the latency of the divider path.
  logic [31:0] dly_r [DQ_DELAY];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= res_r;
      for (int i = 1; i < DQ_DELAY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign real_bits = dly_r[DQ_DELAY-1];

endmodule

`default_nettype wire

>>> rtl/core/affine_8bit_quantizer_core.sv
// Top level of the affine 8-bit quantizer: configuration registers, input and
// output registers, and the quantize and dequantize pipelines. Uses aq_pkg, aq_quant, aq_dequant.
//
//   Channel  Ports                                   Carries
//   input    in_valid, in_ready, in_data             fp32 value, code, last flag
//   output   out_valid, out_ready, out_data          fp32 result, code, bad scale, last
//   config   cfg_valid, cfg_ready, cfg_index, cfg_data  register writes, always ready
//
// One item is accepted every cycle while the output register is empty or taken; a result passes
// the input register, 10 pipeline stages set by the 7-stage divider and the output register.
// All stages advance together whenever the output register is empty or taken,
// so a stall holds every stage in place. Synchronous reset clears the valid
// bits and loads the register reset values; there is no clearing pass.
`default_nettype none

module affine_8bit_quantizer_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  aq_pkg::in_item_t   in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output aq_pkg::out_item_t  out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);
  import aq_pkg::*;

  mode_t       mode_r;
  logic [31:0] scale_r;
  logic [7:0]  zp_r;
  logic        en;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_F2U;
      scale_r <= SCALE_RESET;
      zp_r    <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= mode_t'(cfg_data[1:0]);
        CFG_SCALE: scale_r <= cfg_data;
        CFG_ZP:    zp_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register can take a new item.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  in_item_t s1_r;
  logic     s1_valid_r;
  logic     valid_r [QUANT_LAT];
  logic     last_r  [QUANT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r      <= in_data;
      last_r[0] <= s1_r.last_in;
      for (int i = 1; i < QUANT_LAT; i++) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      for (int i = 0; i < QUANT_LAT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      s1_valid_r <= in_valid;
      valid_r[0] <= s1_valid_r;
      for (int i = 1; i < QUANT_LAT; i++) begin
        valid_r[i] <= valid_r[i-1];
      end
    end
  end

  logic [7:0]  q_code;
  logic [31:0] dq_bits;

  aq_quant u_quant (
    .clk        (clk),
    .en         (en),
    .mode       (mode_r),
    .scale_bits (scale_r),
    .zero_point (zp_r),
    .x_bits     (s1_r.real_value_bits),
    .code       (q_code)
  );

  aq_dequant u_dequant (
    .clk        (clk),
    .en         (en),
    .mode       (mode_r),
    .scale_bits (scale_r),
    .zero_point (zp_r),
    .code       (s1_r.code_in),
    .real_bits  (dq_bits)
  );

  // Output register: pick the path by mode and zero the other field.
  out_item_t out_r, out_nxt;
  logic      out_valid_r;
  logic      is_deq;

  always_comb begin
    is_deq                   = mode_r inside {MODE_U2F, MODE_I2F};
    out_nxt.real_result_bits = is_deq ? dq_bits : 32'd0;
    out_nxt.code_out         = is_deq ? 8'd0 : q_code;
    out_nxt.bad_scale        = (scale_r[30:0] == 31'd0);
    out_nxt.last_out         = last_r[QUANT_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_r[QUANT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for affine_8bit_quantizer_core: it drives random and edge-case
// values through every mode and scale setting, and checks each result against an fp32 model.
// Depends on aq_pkg and on the affine_8bit_quantizer_core RTL.
`timescale 1ns / 100ps

module testbench;
  import aq_pkg::*;

  localparam int LATENCY     = 12;
  localparam int STALL_LIMIT = 600;
  localparam int PHASES      = 24;
  localparam int PHASE_ITEMS = 28;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MODE;
  logic [31:0] cfg_data = '0;

  // Register copies used by the predictor.
  mode_t       cur_mode  = MODE_F2U;
  logic [31:0] cur_scale = SCALE_RESET;
  logic [7:0]  cur_zp    = '0;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  logic      in_taken = 1'b0;
  logic      out_taken = 1'b0;
  int        send_gap = 0;
  int        recv_stall = 0;
  bit        gaps_on = 1'b0;

  affine_8bit_quantizer_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Exact power of two as a double.
  function automatic real pow2(input int k);
    logic [63:0] b;
    b = {1'b0, 11'(k + 1023), 52'b0};
    return $bitstoreal(b);
  endfunction

  // Exact value of an fp32 pattern; infinities and NaNs are handled by callers.
  function automatic real fp32_value(input logic [31:0] f);
    real v;
    if (f[30:23] == 8'd0) v = real'(f[22:0]) * pow2(-149);
    else v = real'({1'b1, f[22:0]}) * pow2(int'(f[30:23]) - 150);
    return f[31] ? -v : v;
  endfunction

  // Round a double to fp32 with round to nearest even, subnormals included.
  function automatic logic [31:0] round_fp32(input real v);
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic        sg;
    int          e;
    int          sh;
    b = $realtobits(v);
    sg = b[63];
    if (b[62:0] == 63'd0) return {sg, 31'b0};
    e = int'(b[62:52]) - 1023;
    m = {11'b0, 1'b1, b[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 54) return {sg, 31'b0};
    kept = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (e >= -126) begin
      if (kept[24]) begin
        kept = kept >> 1;
        e = e + 1;
      end
      if (e > 127) return {sg, 8'hFF, 23'b0};
      return {sg, 8'(e + 127), kept[22:0]};
    end
    // A carry into the hidden bit lands on the smallest normal exponent.
    return {sg, kept[30:0]};
  endfunction

  function automatic bit is_nan(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] != 23'd0;
  endfunction

  function automatic bit is_inf(input logic [31:0] f);
    return f[30:23] == 8'hFF && f[22:0] == 23'd0;
  endfunction

  // fp32 value divided by the scale, rounded half to even, offset and clipped.
  function automatic logic [7:0] quantize_code(input logic [31:0] x, input int zp,
                                               input int lo, input int hi);
    logic [31:0] q;
    real         qv;
    real         frac;
    int          t;
    int          v;
    if (is_nan(x) || is_nan(cur_scale)) return 8'(lo);
    if (cur_scale[30:0] == 31'd0) begin
      if (x[30:0] == 31'd0) return 8'(lo);
      return (x[31] ^ cur_scale[31]) ? 8'(lo) : 8'(hi);
    end
    if (is_inf(x) && is_inf(cur_scale)) return 8'(lo);
    if (is_inf(x)) return (x[31] ^ cur_scale[31]) ? 8'(lo) : 8'(hi);
    if (is_inf(cur_scale)) begin
      q = {x[31] ^ cur_scale[31], 31'b0};
    end else begin
      q = round_fp32(fp32_value(x) / fp32_value(cur_scale));
    end
    if (is_inf(q)) return q[31] ? 8'(lo) : 8'(hi);
    qv = fp32_value(q);
    if (qv >= 512.0) return 8'(hi);
    if (qv <= -512.0) return 8'(lo);
    t = $rtoi(qv);
    frac = qv - real'(t);
    if (frac > 0.5 || (frac == 0.5 && t[0])) t = t + 1;
    else if (frac < -0.5 || (frac == -0.5 && t[0])) t = t - 1;
    v = t + zp;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return 8'(v);
  endfunction

  // Code difference times the scale, as an fp32 pattern.
  function automatic logic [31:0] dequantize_real(input int diff);
    if (is_nan(cur_scale)) return QNAN_BITS;
    if (is_inf(cur_scale)) begin
      if (diff == 0) return QNAN_BITS;
      return {cur_scale[31] ^ (diff < 0), 8'hFF, 23'b0};
    end
    if (diff == 0) return {cur_scale[31], 31'b0};
    if (cur_scale[30:0] == 31'd0) return {cur_scale[31] ^ (diff < 0), 31'b0};
    return round_fp32(real'(diff) * fp32_value(cur_scale));
  endfunction

  function automatic out_item_t convert_item(input in_item_t it);
    out_item_t r;
    r = '0;
    case (cur_mode)
      MODE_F2U: r.code_out = quantize_code(it.real_value_bits, int'(cur_zp), 0, 255);
      MODE_U2F: r.real_result_bits = dequantize_real(int'(it.code_in) - int'(cur_zp));
      MODE_F2I: r.code_out = quantize_code(it.real_value_bits,
                                           int'($signed(cur_zp)), -127, 127);
      default:  r.real_result_bits = dequantize_real(int'($signed(it.code_in))
                                                     - int'($signed(cur_zp)));
    endcase
    r.bad_scale = cur_scale[30:0] == 31'd0;
    r.last_out  = it.last_in;
    return r;
  endfunction

  // Random value: raw or mid-range patterns, scale multiples and half multiples, specials.
  function automatic logic [31:0] pick_value();
    logic [31:0] specials[8];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF};
    case ($urandom_range(0, 9))
      0, 1:       return $urandom;
      2, 3, 4, 5: return round_fp32(fp32_value(cur_scale)
                                    * (real'(int'($urandom_range(0, 1200)) - 600) / 2.0));
      6, 7:       return {1'($urandom), 8'($urandom_range(110, 145)), 23'($urandom)};
      8:          return specials[$urandom_range(0, 7)];
      default:    return round_fp32(fp32_value(cur_scale)
                                    * (real'(int'($urandom_range(0, 40)) - 20) + 0.5));
    endcase
  endfunction

  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, 18) : 0;
  endfunction

  // Input driver: presents queued items at the falling edge.
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_data  <= pending_items.pop_front();
      in_valid <= 1'b1;
      send_gap <= draw_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result-side back pressure, drawn anew after every transfer.
  always @(negedge clk) begin
    int g;
    if (out_taken) begin
      g = draw_gap();
      recv_stall <= (g > 0) ? g - 1 : 0;
      out_ready  <= (g == 0);
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predicts on each input transfer and checks each output transfer.
  always @(posedge clk) begin
    out_item_t exp_r;
    in_taken  <= in_valid && in_ready && rst_n;
    out_taken <= out_valid && out_ready && rst_n;
    if (rst_n && in_valid && in_ready) expected_results.push_back(convert_item(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result transfer: %h", out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r != out_data) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: expected real %h code %h bad %b last %b, got %h %h %b %b",
                     exp_r.real_result_bits, exp_r.code_out, exp_r.bad_scale,
                     exp_r.last_out, out_data.real_result_bits, out_data.code_out,
                     out_data.bad_scale, out_data.last_out);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MODE:  cur_mode  = mode_t'(val[1:0]);
      CFG_SCALE: cur_scale = val;
      default:   cur_zp    = val[7:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic queue_item(input logic [31:0] x, input logic [7:0] c, input logic l);
    in_item_t it;
    it.real_value_bits = x;
    it.code_in = c;
    it.last_in = l;
    pending_items.push_back(it);
  endtask

  initial begin
    logic [31:0] scales[16];
    logic [7:0]  zps[5];
    logic [31:0] directed[16];
    scales = '{32'h3F80_0000, 32'h0000_0000, 32'h8000_0000, 32'h3DCC_CCCD,
               32'h3E00_0000, 32'h406C_CCCD, 32'hBF00_0000, 32'h7FC0_0000,
               32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001, 32'h7F7F_FFFF,
               32'h0DA2_4260, 32'h4B00_0000, 32'hC2C8_0000, 32'hFFFF_FFFF};
    zps = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd1};
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'h3FC0_0000,
                 32'h4020_0000, 32'hBF00_0000, 32'h437E_8000, 32'h437F_8000,
                 32'h4396_0000, 32'hC040_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7149_F2CA, 32'h0000_0001};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Edge values with the reset settings: ties, bounds, infinities, NaN.
    foreach (directed[i]) queue_item(directed[i], (i % 2) ? 8'hFF : 8'h00, i[0]);
    drain();

    // Sweep of settings, each followed by random values.
    for (int p = 0; p < PHASES; p++) begin
      gaps_on = p % 3 != 2;
      write_reg(CFG_MODE, 32'((p + p / 4) % 4));
      write_reg(CFG_SCALE, (p < 16) ? scales[p] : $urandom);
      write_reg(CFG_ZP, (p < 20) ? 32'(zps[p % 5]) : 32'($urandom_range(0, 255)));
      for (int k = 0; k < PHASE_ITEMS; k++)
        queue_item(pick_value(), 8'($urandom_range(0, 255)), 1'($urandom));
      drain();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
